// ----- rtl/spbr_pkg.sv -----
// shared types and constants for the superpixel boundary reassignment core
package spbr_pkg;

	localparam int LABEL_BITS      = 10;
	localparam int SCALE_BITS      = 24;
	localparam int COLOUR_BITS     = 8;
	localparam int COST_OUT_BITS   = 50;
	localparam int NBR_SLOTS       = 8;
	localparam int LANES           = 2;
	localparam int DEF_MAX_SPIX    = 1024;
	localparam int DEF_COORD_BITS  = 12;
	localparam int DEF_NEIGHBOURS  = 8;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd65536;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT
	} st_t;

	typedef enum logic {
		FUNC_LOAD     = 1'b0,
		FUNC_CLASSIFY = 1'b1
	} func_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} beat_t;

endpackage

// ----- rtl/spbr_lane.sv -----
// one cost lane: distance squares, sums, spatial weighting and total cost
module spbr_lane #(
	parameter int COORD_BITS = spbr_pkg::DEF_COORD_BITS,
	parameter int COST_W     = 58
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [spbr_pkg::COLOUR_BITS-1:0]    px_r,
	input  logic [spbr_pkg::COLOUR_BITS-1:0]    px_g,
	input  logic [spbr_pkg::COLOUR_BITS-1:0]    px_b,
	input  logic [COORD_BITS-1:0]               px_x,
	input  logic [COORD_BITS-1:0]               px_y,
	input  logic [spbr_pkg::SCALE_BITS-1:0]     scale,
	input  logic [3*spbr_pkg::COLOUR_BITS+2*COORD_BITS-1:0] entry_s1,
	input  logic                                ok_s1,
	input  logic [spbr_pkg::LABEL_BITS-1:0]     label_s1,
	output logic                                ok_s5,
	output logic [spbr_pkg::LABEL_BITS-1:0]     label_s5,
	output logic [COST_W-1:0]                   cost_s5
);
	import spbr_pkg::*;

	localparam int CSQ_W = 2*COLOUR_BITS;
	localparam int PSQ_W = 2*COORD_BITS;
	localparam int CSUM_W = CSQ_W + 2;
	localparam int PSUM_W = PSQ_W + 1;
	localparam int PROD_W = PSUM_W + SCALE_BITS;

	logic [COLOUR_BITS-1:0] e_r, e_g, e_b, d_r, d_g, d_b;
	logic [COORD_BITS-1:0]  e_x, e_y, d_x, d_y;
	logic [CSQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;
	logic [PSQ_W-1:0] sq_x_s2, sq_y_s2;
	logic [CSUM_W-1:0] csum_s3, csum_s4;
	logic [PSUM_W-1:0] psum_s3;
	logic [PROD_W-1:0] prod_s4;
	logic ok_s2, ok_s3, ok_s4;
	logic [LABEL_BITS-1:0] label_s2, label_s3, label_s4;

	assign {e_r, e_g, e_b, e_x, e_y} = entry_s1;
	assign d_r = (px_r > e_r) ? px_r - e_r : e_r - px_r;
	assign d_g = (px_g > e_g) ? px_g - e_g : e_g - px_g;
	assign d_b = (px_b > e_b) ? px_b - e_b : e_b - px_b;
	assign d_x = (px_x > e_x) ? px_x - e_x : e_x - px_x;
	assign d_y = (px_y > e_y) ? px_y - e_y : e_y - px_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s2 <= 1'b0;
			ok_s3 <= 1'b0;
			ok_s4 <= 1'b0;
			ok_s5 <= 1'b0;
		end else begin
			ok_s2 <= ok_s1;
			ok_s3 <= ok_s2;
			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2  <= CSQ_W'(d_r * d_r);
		sq_g_s2  <= CSQ_W'(d_g * d_g);
		sq_b_s2  <= CSQ_W'(d_b * d_b);
		sq_x_s2  <= PSQ_W'(d_x * d_x);
		sq_y_s2  <= PSQ_W'(d_y * d_y);
		label_s2 <= label_s1;
		csum_s3  <= CSUM_W'(sq_r_s2) + CSUM_W'(sq_g_s2) + CSUM_W'(sq_b_s2);
		psum_s3  <= PSUM_W'(sq_x_s2) + PSUM_W'(sq_y_s2);
		label_s3 <= label_s2;
		prod_s4  <= PROD_W'(psum_s3) * PROD_W'(scale);
		csum_s4  <= csum_s3;
		label_s4 <= label_s3;
		cost_s5  <= COST_W'({csum_s4, 16'd0}) + COST_W'(prod_s4);
		label_s5 <= label_s4;
	end

endmodule

// ----- rtl/spbr_merge.sv -----
// merges the lane costs of each beat into the running best candidate
module spbr_merge #(
	parameter int COST_W = 58
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spbr_pkg::beat_t                 beat_s5,
	input  logic                            ok0,
	input  logic [spbr_pkg::LABEL_BITS-1:0] label0,
	input  logic [COST_W-1:0]               cost0,
	input  logic                            ok1,
	input  logic [spbr_pkg::LABEL_BITS-1:0] label1,
	input  logic [COST_W-1:0]               cost1,
	input  logic                            res_take,
	output logic                            res_valid,
	output logic                            res_found,
	output logic [spbr_pkg::LABEL_BITS-1:0] res_label,
	output logic [COST_W-1:0]               res_cost
);
	import spbr_pkg::*;

	logic                  found_q, f_a, f_b;
	logic [LABEL_BITS-1:0] label_q, l_a, l_b;
	logic [COST_W-1:0]     cost_q, c_a, c_b;

	always_comb begin
		f_a = beat_s5.first ? 1'b0 : found_q;
		l_a = beat_s5.first ? '0 : label_q;
		c_a = beat_s5.first ? '0 : cost_q;
		if (ok0 && (!f_a || cost0 < c_a || (cost0 == c_a && label0 < l_a))) begin
			f_a = 1'b1;
			l_a = label0;
			c_a = cost0;
		end
		f_b = f_a;
		l_b = l_a;
		c_b = c_a;
		if (ok1 && (!f_a || cost1 < c_a || (cost1 == c_a && label1 < l_a))) begin
			f_b = 1'b1;
			l_b = label1;
			c_b = cost1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (beat_s5.valid) begin
				found_q <= f_b;
			end
			if (beat_s5.valid && beat_s5.last) begin
				res_valid <= 1'b1;
			end else if (res_take) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_s5.valid) begin
			label_q <= l_b;
			cost_q  <= c_b;
		end
		if (beat_s5.valid && beat_s5.last) begin
			res_found <= f_b;
			res_label <= l_b;
			res_cost  <= c_b;
		end
	end

endmodule

// ----- rtl/superpixel_boundary_reassign_core.sv -----
// top level: mean table, neighbour sequencer, two cost lanes, merge and output register
// a classify item issues two neighbours per cycle in ceil(NEIGHBOURS/2) rounds
// (four for eight neighbours), set by the two read ports of the mean table
// a classify result passes the table read, lane stages s2 to s5, merge and output registers
// a load item is taken whenever the core is idle; after a classify transfer the next item
// is taken only once the result is registered in the output register
// reset clears control state and sets the spatial weight to 1.0; the mean table is not cleared
module superpixel_boundary_reassign_core #(
	parameter int MAX_SUPERPIXELS = spbr_pkg::DEF_MAX_SPIX,
	parameter int COORD_BITS      = spbr_pkg::DEF_COORD_BITS,
	parameter int NEIGHBOURS      = spbr_pkg::DEF_NEIGHBOURS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spbr_pkg::SCALE_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [9:0]                          entry_index,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic [11:0]                         pos_x,
	input  logic [11:0]                         pos_y,
	input  logic [39:0]                         nbr_labels_lo,
	input  logic [39:0]                         nbr_labels_hi,
	input  logic [7:0]                          nbr_valid,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [spbr_pkg::LABEL_BITS-1:0]     best_label,
	output logic [spbr_pkg::COST_OUT_BITS-1:0]  best_cost,
	output logic                                found
);
	import spbr_pkg::*;

	localparam int IDX_W   = $clog2(MAX_SUPERPIXELS);
	localparam int ENT_W   = 3*COLOUR_BITS + 2*COORD_BITS;
	localparam int ROUNDS  = (NEIGHBOURS + 1) / 2;
	localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int SP_W    = 2*COORD_BITS + 1 + SCALE_BITS;
	localparam int CL_W    = 2*COLOUR_BITS + 2 + 16;
	localparam int RAW_W   = ((SP_W > CL_W) ? SP_W : CL_W) + 1;
	localparam int COST_W  = (RAW_W > COST_OUT_BITS) ? RAW_W : COST_OUT_BITS + 1;

	st_t state_q, state_d;
	logic [RND_W-1:0] round_q;
	logic [SCALE_BITS-1:0] scale_q;
	logic [COLOUR_BITS-1:0] r_q, g_q, b_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [LABEL_BITS-1:0] labels_q [NBR_SLOTS];
	logic [NBR_SLOTS-1:0] nvalid_q;

	logic [ENT_W-1:0] mem [MAX_SUPERPIXELS];
	logic [ENT_W-1:0] rdata_s1 [LANES];
	logic [IDX_W-1:0] raddr [LANES];
	logic ok_i [LANES];
	logic [LABEL_BITS-1:0] label_i [LANES];
	logic ok_s1 [LANES];
	logic [LABEL_BITS-1:0] label_s1 [LANES];
	logic ok_s5 [LANES];
	logic [LABEL_BITS-1:0] label_s5 [LANES];
	logic [COST_W-1:0] cost_s5 [LANES];

	beat_t beat_i, beat_s1, beat_s2, beat_s3, beat_s4, beat_s5;
	logic in_xfer, load_we, issue, last_round;
	logic res_valid, res_found, res_take;
	logic [LABEL_BITS-1:0] res_label;
	logic [COST_W-1:0] res_cost;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign load_we   = in_xfer && (func_t'(func) == FUNC_LOAD)
		&& ({22'd0, entry_index} < 32'(MAX_SUPERPIXELS));
	assign last_round = (round_q == RND_W'(ROUNDS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && func_t'(func) == FUNC_CLASSIFY) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last_round) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_ISSUE: issue = 1'b1;
			ST_WAIT:  in_ready = 1'b0;
			default:  in_ready = 1'b0;
		endcase
	end

	always_comb begin
		beat_i.valid = issue;
		beat_i.first = issue && (round_q == '0);
		beat_i.last  = issue && last_round;
		for (int j = 0; j < LANES; j++) begin
			logic [3:0] n;
			n = 4'(int'(round_q) * LANES + j);
			label_i[j] = labels_q[n[2:0]];
			ok_i[j] = issue && (n < 4'(NEIGHBOURS)) && nvalid_q[n[2:0]]
				&& ({22'd0, label_i[j]} < 32'(MAX_SUPERPIXELS));
			raddr[j] = IDX_W'(label_i[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			scale_q <= SCALE_RESET;
			beat_s1 <= '0;
			beat_s2 <= '0;
			beat_s3 <= '0;
			beat_s4 <= '0;
			beat_s5 <= '0;
			for (int j = 0; j < LANES; j++) begin
				ok_s1[j] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			round_q <= issue ? (last_round ? '0 : round_q + 1'b1) : '0;
			if (cfg_valid && cfg_ready) begin
				scale_q <= cfg_data;
			end
			beat_s1 <= beat_i;
			beat_s2 <= beat_s1;
			beat_s3 <= beat_s2;
			beat_s4 <= beat_s3;
			beat_s5 <= beat_s4;
			for (int j = 0; j < LANES; j++) begin
				ok_s1[j] <= ok_i[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && func_t'(func) == FUNC_CLASSIFY) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
			x_q <= COORD_BITS'(pos_x);
			y_q <= COORD_BITS'(pos_y);
			nvalid_q <= nbr_valid;
			for (int k = 0; k < 4; k++) begin
				labels_q[k]     <= nbr_labels_lo[k*LABEL_BITS +: LABEL_BITS];
				labels_q[k + 4] <= nbr_labels_hi[k*LABEL_BITS +: LABEL_BITS];
			end
		end
		for (int j = 0; j < LANES; j++) begin
			label_s1[j] <= label_i[j];
		end
	end

	// mean table, one write port and two registered read ports
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[IDX_W'(entry_index)] <= {red, green, blue,
				COORD_BITS'(pos_x), COORD_BITS'(pos_y)};
		end
		for (int j = 0; j < LANES; j++) begin
			rdata_s1[j] <= mem[raddr[j]];
		end
	end

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		spbr_lane #(
			.COORD_BITS (COORD_BITS),
			.COST_W     (COST_W)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.px_r     (r_q),
			.px_g     (g_q),
			.px_b     (b_q),
			.px_x     (x_q),
			.px_y     (y_q),
			.scale    (scale_q),
			.entry_s1 (rdata_s1[j]),
			.ok_s1    (ok_s1[j]),
			.label_s1 (label_s1[j]),
			.ok_s5    (ok_s5[j]),
			.label_s5 (label_s5[j]),
			.cost_s5  (cost_s5[j])
		);
	end

	spbr_merge #(
		.COST_W (COST_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_s5   (beat_s5),
		.ok0       (ok_s5[0]),
		.label0    (label_s5[0]),
		.cost0     (cost_s5[0]),
		.ok1       (ok_s5[1]),
		.label1    (label_s5[1]),
		.cost1     (cost_s5[1]),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res_found (res_found),
		.res_label (res_label),
		.res_cost  (res_cost)
	);

	assign res_take = res_valid && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// saturate the cost to the output width
	always_ff @(posedge clk) begin
		if (res_take) begin
			found      <= res_found;
			best_label <= res_label;
			best_cost  <= (|res_cost[COST_W-1:COST_OUT_BITS]) ? '1
				: res_cost[COST_OUT_BITS-1:0];
		end
	end

	a_res_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == ST_WAIT)
		else $error("merge result outside wait state");

	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		beat_s5.valid |-> state_q == ST_WAIT)
		else $error("lane beat while not waiting");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_cost == '0 && best_label == '0)
		else $error("empty result carries data");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !in_ready)
		else $error("input taken during issue");

endmodule

// ----- test/spbr_cost_checker.sv -----
// checker for the superpixel boundary reassignment core: tracks mean table and scale, predicts picks
`timescale 1ns / 1ps
module spbr_cost_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [9:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [39:0] nbr_labels_lo,
	input  logic [39:0] nbr_labels_hi,
	input  logic [7:0]  nbr_valid,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [9:0]  best_label,
	input  logic [49:0] best_cost,
	input  logic        found,
	output int          mismatches,
	output int          picks_pending,
	output int          picks_seen
);
	import spbr_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam longint unsigned COST_CEIL = (64'd1 << 50) - 64'd1;

	typedef struct {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [11:0] x;
		logic [11:0] y;
	} sp_mean_t;

	typedef struct packed {
		logic [9:0]  label;
		logic [49:0] cost;
		logic        hit;
	} pick_t;

	sp_mean_t means [TABLE_DEPTH];
	logic [23:0] scale_q8_16;
	pick_t expected_picks [$];

	function automatic longint unsigned sq_dist(input int unsigned a, input int unsigned b);
		longint unsigned d;
		d = (a > b) ? longint'(a - b) : longint'(b - a);
		return d * d;
	endfunction

	function automatic pick_t nearest_superpixel(input logic [7:0] pr, input logic [7:0] pg,
			input logic [7:0] pb, input logic [11:0] px, input logic [11:0] py,
			input logic [39:0] lo, input logic [39:0] hi, input logic [7:0] vld);
		pick_t p;
		logic [9:0] lbl;
		longint unsigned colour_d, space_d, cost, best;
		bit any;
		any = 0;
		best = 0;
		p = '0;
		for (int k = 0; k < DEF_NEIGHBOURS; k++) begin
			if (!vld[k])
				continue;
			lbl = (k < 4) ? lo[10*k +: 10] : hi[10*(k-4) +: 10];
			if (int'(lbl) >= DEF_MAX_SPIX)
				continue;
			colour_d = sq_dist(pr, means[lbl].r) + sq_dist(pg, means[lbl].g)
				+ sq_dist(pb, means[lbl].b);
			space_d = sq_dist(px, means[lbl].x) + sq_dist(py, means[lbl].y);
			cost = (colour_d << 16) + space_d * longint'(scale_q8_16);
			if (!any || cost < best || (cost == best && lbl < p.label)) begin
				any = 1;
				best = cost;
				p.label = lbl;
			end
		end
		p.hit = any;
		p.cost = (best > COST_CEIL) ? COST_CEIL[49:0] : best[49:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pick_t want;
		if (!arst_n) begin
			scale_q8_16 = SCALE_RESET;
			expected_picks.delete();
			mismatches = 0;
			picks_pending = 0;
			picks_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				picks_seen++;
				if (expected_picks.size() == 0) begin
					mismatches++;
					$display("%0t: result transfer with nothing expected: label %0d cost %0d found %0b",
						$time, best_label, best_cost, found);
				end else begin
					want = expected_picks.pop_front();
					if (best_label !== want.label || best_cost !== want.cost || found !== want.hit) begin
						mismatches++;
						$display("%0t: mismatch expected label %0d cost %0d found %0b, got label %0d cost %0d found %0b",
							$time, want.label, want.cost, want.hit, best_label, best_cost, found);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				scale_q8_16 = cfg_data;
			if (in_valid && in_ready) begin
				if (func_t'(func) == FUNC_LOAD) begin
					if (int'(entry_index) < DEF_MAX_SPIX)
						means[entry_index] = '{red, green, blue, pos_x, pos_y};
				end else begin
					expected_picks.push_back(nearest_superpixel(red, green, blue, pos_x, pos_y,
						nbr_labels_lo, nbr_labels_hi, nbr_valid));
				end
			end
			picks_pending = expected_picks.size();
		end
	end
endmodule

// ----- test/tb_superpixel_boundary_reassign_core.sv -----
// testbench top for the superpixel boundary reassignment core: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb_superpixel_boundary_reassign_core;
	import spbr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [9:0]  entry_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [39:0] nbr_labels_lo;
	logic [39:0] nbr_labels_hi;
	logic [7:0]  nbr_valid;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  best_label;
	logic [49:0] best_cost;
	logic        found;

	int mismatches;
	int picks_pending;
	int picks_seen;

	bit calm;
	bit hold_req;
	bit loaded [1024];
	int loaded_list [$];
	int n_loads;
	int n_classify;
	int n_cfg;

	superpixel_boundary_reassign_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .entry_index(entry_index),
		.red(red), .green(green), .blue(blue), .pos_x(pos_x), .pos_y(pos_y),
		.nbr_labels_lo(nbr_labels_lo), .nbr_labels_hi(nbr_labels_hi), .nbr_valid(nbr_valid),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_label(best_label), .best_cost(best_cost), .found(found)
	);

	spbr_cost_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// receiver pacing, with one long hold-off on request
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
				out_ready <= 1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	task automatic push_item(input func_t f, input logic [9:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [11:0] x,
			input logic [11:0] y, input logic [39:0] lo, input logic [39:0] hi,
			input logic [7:0] v);
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		in_valid <= 1;
		func <= f;
		entry_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		pos_x <= x;
		pos_y <= y;
		nbr_labels_lo <= lo;
		nbr_labels_hi <= hi;
		nbr_valid <= v;
		do @(posedge clk); while (!in_ready);
		if (f == FUNC_LOAD) begin
			n_loads++;
			if (!loaded[idx]) begin
				loaded[idx] = 1;
				loaded_list.push_back(int'(idx));
			end
		end else begin
			n_classify++;
		end
	endtask

	task automatic load_mean(input logic [9:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [11:0] x, input logic [11:0] y);
		push_item(FUNC_LOAD, idx, r, g, b, x, y, 40'({$urandom, $urandom}),
			40'({$urandom, $urandom}), 8'($urandom));
	endtask

	task automatic classify(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [11:0] x, input logic [11:0] y, input logic [39:0] lo,
			input logic [39:0] hi, input logic [7:0] v);
		push_item(FUNC_CLASSIFY, 10'($urandom), r, g, b, x, y, lo, hi, v);
	endtask

	function automatic logic [9:0] any_loaded();
		return 10'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
	endfunction

	function automatic logic [39:0] random_labels();
		logic [39:0] l;
		for (int k = 0; k < 4; k++)
			l[10*k +: 10] = any_loaded();
		return l;
	endfunction

	task automatic drain_then_set_scale(input logic [23:0] s);
		in_valid <= 0;
		while (picks_pending != 0) @(negedge clk);
		repeat (16) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		n_cfg++;
	endtask

	task automatic random_phase(input int count, input int first);
		logic [39:0] lo;
		logic [39:0] hi;
		logic [7:0] v;
		int sel;
		for (int n = 0; n < count; n++) begin
			calm = (first + n >= 150 && first + n < 230);
			if (first + n == 300)
				hold_req = 1;
			if ($urandom_range(99) < 30) begin
				load_mean(10'($urandom_range(1023)), 8'($urandom), 8'($urandom),
					8'($urandom), 12'($urandom), 12'($urandom));
			end else begin
				lo = random_labels();
				hi = random_labels();
				sel = $urandom_range(99);
				v = (sel < 10) ? 8'h00 : (sel < 40) ? 8'hFF : 8'($urandom);
				// duplicated labels force ties between equal costs
				if (sel % 5 == 0)
					hi[9:0] = lo[9:0];
				classify(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom),
					12'($urandom), lo, hi, v);
			end
		end
		calm = 0;
	endtask

	initial begin
		logic [23:0] scales [4];
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		in_valid = 0;
		func = FUNC_LOAD;
		entry_index = '0;
		red = '0;
		green = '0;
		blue = '0;
		pos_x = '0;
		pos_y = '0;
		nbr_labels_lo = '0;
		nbr_labels_hi = '0;
		nbr_valid = '0;
		calm = 0;
		hold_req = 0;
		n_loads = 0;
		n_classify = 0;
		n_cfg = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		drain_then_set_scale(24'd65536);
		load_mean(10'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
		load_mean(10'd1023, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095);
		load_mean(10'd5, 8'd100, 8'd50, 8'd200, 12'd300, 12'd400);
		load_mean(10'd6, 8'd100, 8'd50, 8'd200, 12'd300, 12'd400);
		load_mean(10'd682, 8'd170, 8'd85, 8'd170, 12'd2730, 12'd1365);
		load_mean(10'd341, 8'd85, 8'd170, 8'd85, 12'd1365, 12'd2730);
		// all neighbours valid, extreme pixels
		classify(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, {10'd1023, 10'd682, 10'd341, 10'd0},
			{10'd6, 10'd5, 10'd1023, 10'd0}, 8'hFF);
		classify(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095,
			{10'd0, 10'd341, 10'd682, 10'd1023}, {10'd0, 10'd5, 10'd6, 10'd1023}, 8'hFF);
		// no valid neighbour
		classify(8'd7, 8'd8, 8'd9, 12'd10, 12'd11, {4{10'd1023}}, {4{10'd1023}}, 8'h00);
		// tie between two identical means, larger label first
		classify(8'd90, 8'd60, 8'd190, 12'd310, 12'd390, {10'd0, 10'd0, 10'd5, 10'd6},
			{4{10'd0}}, 8'h03);
		// only the upper neighbours valid
		classify(8'd170, 8'd85, 8'd170, 12'd2730, 12'd1365, {4{10'd5}},
			{10'd0, 10'd1023, 10'd341, 10'd682}, 8'hF0);
		classify(8'd1, 8'd254, 8'd128, 12'd2048, 12'd1, {10'd341, 10'd6, 10'd682, 10'd5},
			{10'd1023, 10'd0, 10'd5, 10'd341}, 8'h5A);

		drain_then_set_scale(24'd0);
		classify(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, {10'd1023, 10'd682, 10'd341, 10'd0},
			{4{10'd5}}, 8'h0F);
		drain_then_set_scale(24'hFFFFFF);
		classify(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, {10'd1023, 10'd682, 10'd341, 10'd0},
			{4{10'd1023}}, 8'hFF);
		classify(8'd255, 8'd0, 8'd255, 12'd4095, 12'd0, {10'd0, 10'd0, 10'd0, 10'd0},
			{10'd1023, 10'd1023, 10'd6, 10'd5}, 8'hC1);

		scales[0] = 24'd65536;
		scales[1] = 24'd0;
		scales[2] = 24'hFFFFFF;
		scales[3] = 24'($urandom);
		for (int p = 0; p < 4; p++) begin
			drain_then_set_scale(scales[p]);
			random_phase(125, 125 * p);
		end
		drain_then_set_scale(24'd1);
		for (int n = 0; n < 10; n++)
			classify(8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom),
				12'($urandom), random_labels(), random_labels(), 8'($urandom));

		in_valid <= 0;
		while (picks_pending != 0) @(negedge clk);
		repeat (30) @(posedge clk);
		$display("run: %0d loads, %0d classify items, %0d results checked, %0d scale writes",
			n_loads, n_classify, picks_seen, n_cfg);
		$display("run: scale extremes 0, 1.0 and max, ties, empty neighbourhoods, long output stall");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/spbr_pkg.sv
rtl/spbr_lane.sv
rtl/spbr_merge.sv
rtl/superpixel_boundary_reassign_core.sv
test/spbr_cost_checker.sv
test/tb_superpixel_boundary_reassign_core.sv
